// ===== design/bsld_pkg.sv =====
// ----------------------------------------------------------------------------
// bsld_pkg: shared types and constants of the button press detector
// Button count, field widths and the reset value of the long-press threshold.
// ----------------------------------------------------------------------------
package bsld_pkg;

	localparam int NUM_BUTTONS = 2;
	localparam int BTN_IDX_W   = 1;
	localparam int THR_W       = 10;

	typedef logic [NUM_BUTTONS-1:0] levels_t;
	typedef logic [BTN_IDX_W-1:0]   btn_idx_t;
	typedef logic [THR_W-1:0]       thr_t;

	// 2000 ms hold time at a 20 ms poll period
	localparam thr_t THR_RESET = thr_t'(2000 / 20);

endpackage

// ===== design/bsld_if.sv =====
// ----------------------------------------------------------------------------
// bsld_if: valid/ready channels of the button press detector
// Poll channel in, event channel out, threshold write channel.
// ----------------------------------------------------------------------------
interface bsld_poll_if;
	import bsld_pkg::*;

	logic    valid;
	logic    ready;
	levels_t pin_levels;

	modport source (output valid, output pin_levels, input ready);
	modport sink   (input valid, input pin_levels, output ready);
endinterface

interface bsld_evt_if;
	import bsld_pkg::*;

	logic     valid;
	logic     ready;
	btn_idx_t button_index;
	logic     long_press;
	logic     last_event;

	modport source (output valid, output button_index, output long_press,
		output last_event, input ready);
	modport sink   (input valid, input button_index, input long_press,
		input last_event, output ready);
endinterface

interface bsld_cfg_if;
	import bsld_pkg::*;

	logic valid;
	logic ready;
	thr_t long_press_polls;

	modport source (output valid, output long_press_polls, input ready);
	modport sink   (input valid, input long_press_polls, output ready);
endinterface

// ===== design/button_short_long_press_detector.sv =====
// Timing: a poll transferred into the poll stage loads its events into the result
//   register when it advances, and they are offered from that register.
// Throughput: one poll per cycle while no events are pending; the event register
//   drains one event per cycle while evt.ready is high, so a poll that causes
//   events keeps the next poll in the poll stage until its last event transfers.
// Reset: clears all per-button state and pending events, threshold set to 100.
// ----------------------------------------------------------------------------
// button_short_long_press_detector: debounced short/long press events
// Each poll carries the active-low levels of all buttons. A poll register feeds
// per-button debounce and hold counting; events go to a result register that
// hands them out lowest button first.
// ----------------------------------------------------------------------------
module button_short_long_press_detector #(
	parameter int COUNT_WIDTH = 10
) (
	input  logic        clk,
	input  logic        arst_n,
	bsld_poll_if.sink   poll,
	bsld_evt_if.source  evt,
	bsld_cfg_if.sink    cfg
);
	import bsld_pkg::*;

	localparam int CMP_W = (COUNT_WIDTH > THR_W) ? COUNT_WIDTH : THR_W;

	// poll stage
	logic    valid_s1;
	levels_t levels_s1;

	// per-button state
	levels_t                prev_q;
	levels_t                stable_q;
	levels_t                fired_q;
	logic [COUNT_WIDTH-1:0] cnt_q [NUM_BUTTONS];
	thr_t                   thr_q;

	// next state and events of the poll in the stage
	levels_t                pressed_w;
	levels_t                prev_nxt;
	levels_t                stable_nxt;
	levels_t                fired_nxt;
	logic [COUNT_WIDTH-1:0] cnt_nxt [NUM_BUTTONS];
	levels_t                emask;
	levels_t                elong;

	// result register
	levels_t  pend_q;
	levels_t  pend_long_q;
	levels_t  low_oh;
	btn_idx_t low_idx;
	logic     pend_last;
	logic     evt_xfer;
	logic     s1_adv;

	// threshold register
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THR_RESET;
		end else if (cfg.valid && cfg.ready) begin
			thr_q <= cfg.long_press_polls;
		end
	end

	// handshake control
	assign evt_xfer  = evt.valid && evt.ready;
	assign s1_adv    = valid_s1 && ((pend_q == '0) || (evt_xfer && pend_last));
	assign poll.ready = !valid_s1 || s1_adv;

	// hold the poll until its events can enter the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (poll.ready) begin
			valid_s1 <= poll.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (poll.valid && poll.ready) begin
			levels_s1 <= poll.pin_levels;
		end
	end

	// debounce, press/release and hold counting per button
	assign pressed_w = ~levels_s1;

	always_comb begin
		for (int i = 0; i < NUM_BUTTONS; i++) begin
			prev_nxt[i]   = prev_q[i];
			stable_nxt[i] = stable_q[i];
			fired_nxt[i]  = fired_q[i];
			cnt_nxt[i]    = cnt_q[i];
			emask[i]      = 1'b0;
			elong[i]      = 1'b0;
			if (pressed_w[i] != prev_q[i]) begin
				prev_nxt[i] = pressed_w[i];
			end else begin
				if (pressed_w[i] != stable_q[i]) begin
					stable_nxt[i] = pressed_w[i];
					if (pressed_w[i]) begin
						cnt_nxt[i]   = '0;
						fired_nxt[i] = 1'b0;
					end else if (!fired_q[i]) begin
						emask[i] = 1'b1;
					end
				end
				if (pressed_w[i] && !fired_nxt[i]) begin
					if (CMP_W'(cnt_nxt[i]) >= CMP_W'(thr_q)) begin
						fired_nxt[i] = 1'b1;
						emask[i]     = 1'b1;
						elong[i]     = 1'b1;
					end else if (!(&cnt_nxt[i])) begin
						cnt_nxt[i] = cnt_nxt[i] + COUNT_WIDTH'(1);
					end
				end
			end
		end
	end

	// advance button state with the poll
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q   <= '0;
			stable_q <= '0;
			fired_q  <= '0;
			for (int i = 0; i < NUM_BUTTONS; i++) begin
				cnt_q[i] <= '0;
			end
		end else if (s1_adv) begin
			prev_q   <= prev_nxt;
			stable_q <= stable_nxt;
			fired_q  <= fired_nxt;
			for (int i = 0; i < NUM_BUTTONS; i++) begin
				cnt_q[i] <= cnt_nxt[i];
			end
		end
	end

	// pick the lowest pending button
	assign low_oh    = pend_q & (~pend_q + levels_t'(1));
	assign pend_last = (pend_q & (pend_q - levels_t'(1))) == '0;

	always_comb begin
		low_idx = '0;
		for (int i = 0; i < NUM_BUTTONS; i++) begin
			if (low_oh[i]) begin
				low_idx = btn_idx_t'(i);
			end
		end
	end

	// load events of a poll, drop each one after its transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else if (s1_adv) begin
			pend_q <= emask;
		end else if (evt_xfer) begin
			pend_q <= pend_q & ~low_oh;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			pend_long_q <= elong;
		end
	end

	assign evt.valid        = |pend_q;
	assign evt.button_index = low_idx;
	assign evt.long_press   = |(low_oh & pend_long_q);
	assign evt.last_event   = pend_last;

	// a pending long event needs a held button, a pending short one a released button
	a_pend_kind: assert property (@(posedge clk) disable iff (!arst_n)
		(pend_q & (pend_long_q ^ stable_q)) == '0)
		else $error("pending event kind disagrees with button state");

	// an accepted poll occupies the poll stage next cycle
	a_poll_held: assert property (@(posedge clk) disable iff (!arst_n)
		poll.valid && poll.ready |=> valid_s1)
		else $error("accepted poll lost");

	// events of one poll come out without a gap
	a_evt_burst: assert property (@(posedge clk) disable iff (!arst_n)
		evt_xfer && !evt.last_event |=> evt.valid)
		else $error("event burst broken before last event");

	// within one poll, events leave in rising button order
	a_evt_order: assert property (@(posedge clk) disable iff (!arst_n)
		evt_xfer && !evt.last_event |=> evt.button_index > $past(evt.button_index))
		else $error("events out of button order");

endmodule
